FILE: sv/assert_macros.svh
// Assertion macros shared by the frame task timer RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame task timer check failed");

// Next-cycle implication, checked outside reset
`define FTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame task timer check failed");

`endif

FILE: sv/ftt_pkg.sv
// Shared types and constants for the frame task timer.
// No dependencies; imported by every RTL module of the block.
package ftt_pkg;

  // Command codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_PAUSE  = 2'd2,
    KIND_RESET  = 2'd3
  } ftt_kind_t;

  localparam int TIME_W  = 32;             // millisecond values
  localparam int DELTA_W = 48;             // Q32.16 seconds
  localparam int FRAC_W  = 16;             // fraction bits of the delta
  localparam int CNT_W   = 6;              // divider step counter

  // Divider step count: ticks / divisor
  localparam logic [CNT_W-1:0] NOW_STEPS = CNT_W'(TIME_W);

  // x / 1000 for any 32-bit x is (x * RECIP_1000) >> RECIP_SHIFT
  localparam logic [TIME_W-1:0] RECIP_1000  = 32'h1062_4DD3;
  localparam int                RECIP_SHIFT = 38;

  localparam logic [TIME_W-1:0] MS_PER_SEC = TIME_W'(1000);
  localparam logic [TIME_W-1:0] ROUND_BIAS = TIME_W'(500);

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;     // latch the input beat
    logic div_now;     // start ticks / divisor
    logic calc_cur;    // register the new current time
    logic div_delta;   // start scaling the diff into Q32.16 seconds
    logic commit;      // update state and load the output beat
  } ftt_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic need_div;    // command samples the clock with a valid divisor
    logic is_start;    // latched command is a start
    logic div_done;    // divider or delta scaling finished this cycle
    logic out_free;    // output register can take a beat
  } ftt_stat_t;

endpackage

FILE: sv/ftt_in_if.sv
// Command channel of the frame task timer: valid/ready plus payload.
// No dependencies.
interface ftt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] raw_ticks;
  logic [31:0] divisor;

  modport source (output valid, kind, raw_ticks, divisor, input ready);
  modport sink   (input valid, kind, raw_ticks, divisor, output ready);
endinterface

FILE: sv/ftt_out_if.sv
// Result channel of the frame task timer: valid/ready plus payload.
// No dependencies.
interface ftt_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] current_time_ms;
  logic [47:0] delta_seconds_q16;
  logic        running;

  modport source (output valid, status, current_time_ms, delta_seconds_q16, running,
                  input ready);
  modport sink   (input valid, status, current_time_ms, delta_seconds_q16, running,
                  output ready);
endinterface

FILE: sv/ftt_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend and divisor.
// Depends on ftt_pkg.
module ftt_div
  import ftt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient
);

  logic [TIME_W-1:0] dsr;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvd;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W:0]   rem_sh;
  logic              ge;
  logic [TIME_W:0]   rem_sub;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem, dvd[TIME_W-1]};
    ge      = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (go) begin
      cnt  <= NOW_STEPS;
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      dsr      <= divisor;
      rem      <= '0;
      dvd      <= dividend;
      quotient <= '0;
    end else if (cnt != '0) begin
      rem      <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      dvd      <= {dvd[TIME_W-2:0], 1'b0};
      quotient <= {quotient[TIME_W-2:0], ge};
    end
  end

endmodule

FILE: sv/ftt_ctrl.sv
// Sequencer of the frame task timer: one command at a time through the datapath.
// Depends on ftt_pkg.
module ftt_ctrl
  import ftt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ftt_stat_t stat,
  output ftt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_NOW,
    S_CUR,
    S_DELTA,
    S_DIV_DELTA,
    S_FINISH
  } state_t;

  state_t state;

  // commands decoded from state
  always_comb begin
    cmd           = '0;
    in_ready      = (state == S_IDLE);
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.div_now   = (state == S_DECODE) && stat.need_div;
    cmd.calc_cur  = (state == S_CUR);
    cmd.div_delta = (state == S_DELTA);
    cmd.commit    = (state == S_FINISH) && stat.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          state <= stat.need_div ? S_DIV_NOW : S_FINISH;
        end
        S_DIV_NOW: begin
          if (stat.div_done) state <= stat.is_start ? S_FINISH : S_CUR;
        end
        S_CUR: begin
          state <= S_DELTA;
        end
        S_DELTA: begin
          state <= S_DIV_DELTA;
        end
        S_DIV_DELTA: begin
          if (stat.div_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ftt_dp.sv
// Datapath of the frame task timer: input latch, timer state, divider, delta scaling,
// output register. Depends on ftt_pkg, ftt_div.
module ftt_dp
  import ftt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [1:0]         in_kind,
  input  logic [TIME_W-1:0]  in_raw_ticks,
  input  logic [TIME_W-1:0]  in_divisor,
  input  ftt_cmd_t           cmd,
  output ftt_stat_t          stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_status,
  output logic [TIME_W-1:0]  out_current_time_ms,
  output logic [DELTA_W-1:0] out_delta_seconds_q16,
  output logic               out_running
);

  logic               relative_mode;
  logic               active_flag;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W-1:0]  paused_time;
  logic [TIME_W-1:0]  current_time;
  logic [DELTA_W-1:0] last_delta;

  ftt_kind_t          kind;
  logic [TIME_W-1:0]  raw_ticks;
  logic [TIME_W-1:0]  divisor;
  logic [TIME_W-1:0]  cur;

  logic               div_zero;
  logic               div_done;
  logic [TIME_W-1:0]  quotient;
  logic [TIME_W-1:0]  diff;

  logic [4:0]          scl_stage;
  logic [TIME_W-1:0]   scl_diff;
  logic [2*TIME_W-1:0] scl_prod;
  logic [TIME_W-1:0]   scl_mul_in;
  logic [TIME_W-1:0]   scl_quot;
  logic [TIME_W-1:0]   scl_rem;
  logic [TIME_W-1:0]   scl_whole;
  logic [TIME_W-1:0]   scl_rest;
  logic [DELTA_W-1:0]  scl_q16;

  logic               status_next;
  logic               active_next;
  logic [TIME_W-1:0]  start_next;
  logic [TIME_W-1:0]  paused_next;
  logic [TIME_W-1:0]  current_next;
  logic [DELTA_W-1:0] delta_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      relative_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      relative_mode <= cfg_wr_data;
    end
  end

  // input beat latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind      <= ftt_kind_t'(in_kind);
      raw_ticks <= in_raw_ticks;
      divisor   <= in_divisor;
    end
  end

  assign div_zero = (divisor == '0);

  // new current time from the sampled millisecond count
  always_ff @(posedge clk) begin
    if (cmd.calc_cur) begin
      cur <= relative_mode ? quotient - start_time + paused_time
                           : quotient;
    end
  end

  assign diff = cur - current_time;

  // ticks / divisor
  ftt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_now),
    .dividend (raw_ticks),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // delta scaling: (diff * 65536 + 500) / 1000 split as whole = diff / 1000 and
  // rest = (diff % 1000) * 65536 + 500, giving whole * 65536 + rest / 1000.
  // Both divides by 1000 share one 32x32 reciprocal multiply.
  // Stage bits: 0 multiply diff, 1 whole and rest, 2 multiply rest, 3 sum, 4 done.
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_stage <= '0;
    end else begin
      scl_stage <= {scl_stage[3:0], cmd.div_delta};
    end
  end

  assign scl_mul_in = scl_stage[0] ? scl_diff : scl_rest;
  assign scl_quot   = TIME_W'(scl_prod >> RECIP_SHIFT);
  assign scl_rem    = scl_diff - scl_quot * MS_PER_SEC;

  always_ff @(posedge clk) begin
    if (cmd.div_delta) begin
      scl_diff <= diff;
    end
    if (scl_stage[0] || scl_stage[2]) begin
      scl_prod <= {{TIME_W{1'b0}}, scl_mul_in} * {{TIME_W{1'b0}}, RECIP_1000};
    end
    if (scl_stage[1]) begin
      scl_whole <= scl_quot;
      scl_rest  <= (scl_rem << FRAC_W) | ROUND_BIAS;
    end
    if (scl_stage[3]) begin
      scl_q16 <= ({{FRAC_W{1'b0}}, scl_whole} << FRAC_W) + DELTA_W'(scl_quot);
    end
  end

  // status toward the controller
  always_comb begin
    stat.need_div = !div_zero &&
                    ((kind == KIND_START) || ((kind == KIND_UPDATE) && active_flag));
    stat.is_start = (kind == KIND_START);
    stat.div_done = div_done | scl_stage[4];
    stat.out_free = !out_valid || out_ready;
  end

  // state update per command
  always_comb begin
    status_next  = 1'b0;
    active_next  = active_flag;
    start_next   = start_time;
    paused_next  = paused_time;
    current_next = current_time;
    delta_next   = last_delta;
    case (kind)
      KIND_UPDATE: begin
        if (!active_flag) begin
          delta_next = '0;
        end else if (div_zero) begin
          status_next = 1'b1;
        end else begin
          delta_next   = scl_q16;
          current_next = cur;
        end
      end
      KIND_START: begin
        if (div_zero) begin
          status_next = 1'b1;
        end else begin
          start_next  = quotient;
          active_next = 1'b1;
        end
      end
      KIND_PAUSE: begin
        paused_next = current_time;
        active_next = 1'b0;
      end
      KIND_RESET: begin
        start_next   = '0;
        paused_next  = '0;
        current_next = '0;
        active_next  = 1'b0;
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag  <= 1'b0;
      start_time   <= '0;
      paused_time  <= '0;
      current_time <= '0;
      last_delta   <= '0;
    end else if (cmd.commit) begin
      active_flag  <= active_next;
      start_time   <= start_next;
      paused_time  <= paused_next;
      current_time <= current_next;
      last_delta   <= delta_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status            <= status_next;
      out_current_time_ms   <= current_next;
      out_delta_seconds_q16 <= delta_next;
      out_running           <= active_next;
    end
  end

endmodule

FILE: sv/frame_task_timer_unit.sv
// Frame task timer: takes update, start, pause and reset commands one at a time and
// answers each with one result beat. Pause, reset, an update while stopped and any
// command refused for a zero divisor go straight to the result; start runs the 32
// steps of the bit-serial ticks / divisor divider; an update while running runs the
// same divide followed by a short reciprocal-multiply pass that turns the millisecond
// delta into Q32.16 seconds. The next command can be accepted at the same edge at
// which the result can first be taken. A new command is taken only while the sequencer
// is idle; a result waiting in the output register does not hold off the next command,
// but the following result waits in the sequencer until the output register frees.
// Depends on ftt_pkg, ftt_in_if, ftt_out_if, ftt_ctrl, ftt_dp, assert_macros.svh.
`include "assert_macros.svh"

module frame_task_timer_unit
  import ftt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  ftt_in_if.sink    in_ch,
  ftt_out_if.source out_ch
);

  ftt_cmd_t  cmd;
  ftt_stat_t stat;

  // sequencer
  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // timer datapath
  ftt_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_kind               (in_ch.kind),
    .in_raw_ticks          (in_ch.raw_ticks),
    .in_divisor            (in_ch.divisor),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_status            (out_ch.status),
    .out_current_time_ms   (out_ch.current_time_ms),
    .out_delta_seconds_q16 (out_ch.delta_seconds_q16),
    .out_running           (out_ch.running)
  );

  // a captured command blocks the input until it is finished
  `FTT_ASSERT_NEXT(a_busy_after_capture, cmd.capture, !in_ch.ready)
  // results are only loaded into a free output register
  `FTT_ASSERT_NOW(a_commit_when_free, cmd.commit, stat.out_free)
  // a taken result beat leaves unless a new one is loaded
  `FTT_ASSERT_NEXT(a_out_drains, out_ch.valid && out_ch.ready && !cmd.commit, !out_ch.valid)
  // the divider never finishes while the sequencer is idle
  `FTT_ASSERT_NOW(a_no_done_idle, in_ch.ready, !stat.div_done)

endmodule

FILE: test/tb_frame_task_timer_unit.sv
`timescale 1ns / 1ps
// Testbench for frame_task_timer_unit: directed and random command traffic checked against
// an in-bench model of the timer. Depends on ftt_pkg, ftt_in_if, ftt_out_if and the RTL.
module tb_frame_task_timer_unit
  import ftt_pkg::*;
();

  // One result beat as seen on the output channel
  typedef struct packed {
    logic        status;
    logic [31:0] cur_ms;
    logic [47:0] delta_q16;
    logic        running;
  } timer_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  ftt_in_if  in_ch();
  ftt_out_if out_ch();

  frame_task_timer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Model state of the timer
  logic        rel_mode;
  logic        tmr_active;
  logic [31:0] tmr_start;
  logic [31:0] tmr_paused;
  logic [31:0] tmr_current;
  logic [47:0] tmr_delta;

  timer_result_t expected_results[$];

  int src_idle_pct;
  int snk_idle_pct;
  int hold_req;
  int hold_left;
  int cmds_sent;
  int results_checked;
  int rejects_seen;
  int mismatches;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Expected timer behavior for one command; updates the model state
  function automatic timer_result_t predict_timer(input ftt_kind_t kind,
                                                  input logic [31:0] ticks,
                                                  input logic [31:0] div);
    timer_result_t r;
    logic [31:0]   now_ms;
    logic [31:0]   cur_ms;
    logic [31:0]   diff_ms;
    logic [63:0]   scaled;
    r.status = 1'b0;
    case (kind)
      KIND_UPDATE: begin
        if (!tmr_active) begin
          tmr_delta = '0;
        end else if (div == 32'd0) begin
          r.status = 1'b1;
        end else begin
          now_ms  = ticks / div;
          cur_ms  = rel_mode ? now_ms - tmr_start + tmr_paused : now_ms;
          diff_ms = cur_ms - tmr_current;
          // diff ms -> seconds in Q32.16, rounded to nearest
          scaled    = ({32'd0, diff_ms} << 16) + 64'd500;
          tmr_delta = 48'(scaled / 64'd1000);
          tmr_current = cur_ms;
        end
      end
      KIND_START: begin
        if (div == 32'd0) begin
          r.status = 1'b1;
        end else begin
          tmr_start  = ticks / div;
          tmr_active = 1'b1;
        end
      end
      KIND_PAUSE: begin
        tmr_paused = tmr_current;
        tmr_active = 1'b0;
      end
      default: begin
        tmr_start   = '0;
        tmr_paused  = '0;
        tmr_current = '0;
        tmr_active  = 1'b0;
      end
    endcase
    if (r.status) rejects_seen++;
    r.cur_ms    = tmr_current;
    r.delta_q16 = tmr_delta;
    r.running   = tmr_active;
    return r;
  endfunction

  // Offer one command beat; returns at the accepting edge with valid still high
  task automatic send_cmd(input ftt_kind_t kind, input logic [31:0] ticks,
                          input logic [31:0] div);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.raw_ticks <= ticks;
    in_ch.divisor   <= div;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.insert(expected_results.size(), predict_timer(kind, ticks, div));
    cmds_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rel_mode = mode;
  endtask

  function automatic logic [31:0] pick_divisor();
    case ($urandom_range(7))
      0:       return 32'd1;
      1:       return 32'($urandom_range(2, 16));
      2:       return 32'd1000;
      3:       return 32'($urandom_range(1, 100000));
      4:       return 32'hFFFF_FFFF;
      5:       return $urandom | 32'd1;
      default: return 32'($urandom_range(1, 1000));
    endcase
  endfunction

  // Start, a run of frame updates, then pause / resume / reset / nothing
  task automatic send_frame_run();
    logic [31:0] div;
    logic [31:0] ticks;
    int          n_upd;
    div   = pick_divisor();
    ticks = $urandom;
    n_upd = $urandom_range(1, 8);
    send_cmd(KIND_START, ticks, div);
    repeat (n_upd) begin
      ticks = ticks + 32'($urandom_range(0, 40)) * div + 32'($urandom_range(0, 3));
      if ($urandom_range(99) < 8) send_cmd(KIND_UPDATE, ticks, 32'd0);
      else send_cmd(KIND_UPDATE, ticks, div);
    end
    case ($urandom_range(3))
      0: begin
        send_cmd(KIND_PAUSE, $urandom, $urandom);
        if ($urandom_range(1)) send_cmd(KIND_UPDATE, $urandom, $urandom);
      end
      1: begin
        // pause, resume later, a few more frames
        send_cmd(KIND_PAUSE, $urandom, $urandom);
        ticks = ticks + 32'($urandom_range(0, 500)) * div;
        send_cmd(KIND_START, ticks, div);
        repeat ($urandom_range(1, 3)) begin
          ticks = ticks + 32'($urandom_range(0, 40)) * div;
          send_cmd(KIND_UPDATE, ticks, div);
        end
      end
      2: send_cmd(KIND_RESET, $urandom, $urandom);
      default: ;
    endcase
  endtask

  // Mostly frame runs, some fully random commands
  task automatic send_traffic(input int n_items);
    int goal;
    goal = cmds_sent + n_items;
    while (cmds_sent < goal) begin
      if ($urandom_range(99) < 20)
        send_cmd(ftt_kind_t'($urandom_range(3)), $urandom,
                 ($urandom_range(3) == 0) ? 32'd0 : $urandom);
      else
        send_frame_run();
    end
  endtask

  // Corner cases in both modes
  task automatic test_directed();
    write_mode(1'b0);
    send_cmd(KIND_UPDATE, 32'hFFFF_FFFF, 32'd0);   // stopped: no error
    send_cmd(KIND_START,  32'd5,         32'd0);   // zero divisor rejected
    send_cmd(KIND_START,  32'd0,         32'd1);
    send_cmd(KIND_UPDATE, 32'hFFFF_FFFF, 32'd1);   // largest diff
    send_cmd(KIND_UPDATE, 32'd3,         32'd0);   // zero divisor while running
    send_cmd(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // diff wraps
    send_cmd(KIND_UPDATE, 32'd1,         32'd1);   // zero diff
    send_cmd(KIND_UPDATE, 32'd1001,      32'd2);   // rounding
    send_cmd(KIND_PAUSE,  32'd0,         32'd0);
    send_cmd(KIND_UPDATE, 32'd77,        32'd1);   // stopped clears delta
    send_cmd(KIND_RESET,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    write_mode(1'b1);
    send_cmd(KIND_START,  32'd2000,      32'd2);
    send_cmd(KIND_UPDATE, 32'd2600,      32'd2);
    send_cmd(KIND_UPDATE, 32'd2601,      32'd2);
    send_cmd(KIND_PAUSE,  32'd0,         32'd0);
    send_cmd(KIND_START,  32'd10,        32'd1);   // resume keeps paused time
    send_cmd(KIND_UPDATE, 32'd15,        32'd1);
    send_cmd(KIND_UPDATE, 32'd5,         32'd1);   // time runs backward
    send_cmd(KIND_START,  32'hFFFF_FFFF, 32'd1);   // restart while running
    send_cmd(KIND_UPDATE, 32'd0,         32'd1);
    send_cmd(KIND_RESET,  32'd0,         32'd0);
    send_cmd(KIND_UPDATE, 32'd0,         32'd0);
    wait_drained();
  endtask

  // Random frames under one idle profile, both modes
  task automatic test_random_frames(input int src_pct, input int snk_pct, input int n_items);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int sub = 0; sub < 3; sub++) begin
      wait_drained();
      write_mode(sub == 2 ? 1'($urandom_range(1)) : sub[0]);
      send_traffic(n_items / 3);
    end
  endtask

  // Receiver holds off while commands keep coming, then a full drain
  task automatic test_backpressure();
    hold_req = 600;
    send_traffic(30);
    wait_drained();
  endtask

  // Receiver: random ready, or a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Result checker
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.current_time_ms, out_ch.delta_seconds_q16,
              out_ch.running};
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat status=%0d cur=%0d delta=%0h run=%0d",
                                got.status, got.cur_ms, got.delta_q16, got.running));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.status !== want.status || got.cur_ms !== want.cur_ms ||
            got.delta_q16 !== want.delta_q16 || got.running !== want.running)
          note_mismatch($sformatf({"exp status=%0d cur=%0d delta=%0h run=%0d, ",
                                   "got status=%0d cur=%0d delta=%0h run=%0d"},
                                  want.status, want.cur_ms, want.delta_q16, want.running,
                                  got.status, got.cur_ms, got.delta_q16, got.running));
      end
    end
  end

  // Main sequence
  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_UPDATE;
    in_ch.raw_ticks = '0;
    in_ch.divisor   = '0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    hold_req        = 0;
    cmds_sent       = 0;
    results_checked = 0;
    rejects_seen    = 0;
    mismatches      = 0;
    rel_mode        = 1'b0;
    tmr_active      = 1'b0;
    tmr_start       = '0;
    tmr_paused      = '0;
    tmr_current     = '0;
    tmr_delta       = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_frames(32, 82, 330);
    test_random_frames(82, 32, 330);
    test_random_frames(0, 0, 330);
    test_backpressure();

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Ran %0d timer commands over absolute and relative modes, three idle profiles",
             cmds_sent);
    $display("and a long output hold-off: %0d results checked, %0d zero-divisor rejects.",
             results_checked, rejects_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
